FILE: sv/tkips_pkg.sv
package tkips_pkg;

  // Field widths of the stream items and configuration registers.
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 9;
  localparam int ELEM_W  = 16;
  localparam int KIND_W  = 2;
  localparam int RANK_W  = 3;
  localparam int SCORE_W = 39;
  localparam int VLEN_W  = 10;
  localparam int HLIM_W  = 4;
  localparam int CFGI_W  = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HIT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOHIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_VLEN = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_HLIM = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_THR  = 2'd2;

  // Configuration reset values.
  localparam logic [VLEN_W-1:0] VLEN_RST = 10'd128;
  localparam logic [HLIM_W-1:0] HLIM_RST = 4'd5;

  // Score saturation limits.
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic remove;
    logic query_wr;
    logic search_start;
    logic slot_next;
    logic mac_start;
    logic mac_step;
    logic insert;
    logic load_resp;
    logic load_hit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_ok;
    logic is_final;
    logic slot_done;
    logic slot_valid;
    logic mac_last;
    logic pipe_busy;
    logic emit_done;
    logic can_load;
  } sts_t;

endpackage

FILE: sv/tkips_ram.sv
module tkips_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tkips_ctrl.sv
module tkips_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [tkips_pkg::MODE_W-1:0] in_mode,
  input  tkips_pkg::sts_t              sts,
  output logic                         in_ready,
  output tkips_pkg::cmd_t              cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_RESP   = 8'b00000010,
    ST_SLOT   = 8'b00000100,
    ST_MAC    = 8'b00001000,
    ST_DRAIN  = 8'b00010000,
    ST_INSERT = 8'b00100000,
    ST_EMIT   = 8'b01000000,
    ST_SPARE  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic   in_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            tkips_pkg::MODE_STORE: begin
              cmd.store = 1'b1;
            end
            tkips_pkg::MODE_REMOVE: begin
              cmd.remove = 1'b1;
              state_next = ST_RESP;
            end
            tkips_pkg::MODE_QUERY: begin
              cmd.query_wr = sts.in_ok;
              if (sts.in_ok && sts.is_final) begin
                cmd.search_start = 1'b1;
                state_next       = ST_SLOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        if (sts.can_load) begin
          cmd.load_resp = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_SLOT: begin
        if (sts.slot_done) begin
          state_next = ST_EMIT;
        end else if (sts.slot_valid) begin
          cmd.mac_start = 1'b1;
          state_next    = ST_MAC;
        end else begin
          cmd.slot_next = 1'b1;
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (sts.mac_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.insert    = 1'b1;
        cmd.slot_next = 1'b1;
        state_next    = ST_SLOT;
      end
      ST_EMIT: begin
        if (sts.can_load) begin
          cmd.load_hit = 1'b1;
          if (sts.emit_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/tkips_dp.sv
module tkips_dp #(
  parameter int MAX_SLOTS  = 64,
  parameter int MAX_LENGTH = 512,
  parameter int MAX_HITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tkips_pkg::CFGI_W-1:0]        cfg_index,
  input  logic [tkips_pkg::SCORE_W-1:0]       cfg_data,
  input  logic [tkips_pkg::SLOT_W-1:0]        in_slot,
  input  logic [tkips_pkg::IDX_W-1:0]         in_idx,
  input  logic [tkips_pkg::ELEM_W-1:0]        in_value,
  input  tkips_pkg::cmd_t                     cmd,
  output tkips_pkg::sts_t                     sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [tkips_pkg::KIND_W-1:0]        out_kind,
  output logic                                out_was_present,
  output logic [tkips_pkg::SLOT_W-1:0]        out_hit_slot,
  output logic signed [tkips_pkg::SCORE_W-1:0] out_hit_score,
  output logic [tkips_pkg::RANK_W-1:0]        out_hit_rank,
  output logic                                out_last
);

  localparam int GDEPTH = MAX_SLOTS * MAX_LENGTH;
  localparam int GAW    = GDEPTH > 1 ? $clog2(GDEPTH) : 1;
  localparam int QAW    = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1;
  localparam int SIW    = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int SCW    = $clog2(MAX_SLOTS + 1);
  localparam int HIW    = MAX_HITS > 1 ? $clog2(MAX_HITS) : 1;
  localparam int HCW    = $clog2(MAX_HITS + 1);
  localparam int ACCW   = 2 * tkips_pkg::ELEM_W + $clog2(MAX_LENGTH + 1) + 1;
  localparam int SW     = tkips_pkg::SCORE_W;

  // Configuration registers.
  logic [tkips_pkg::VLEN_W-1:0] vector_length;
  logic [tkips_pkg::HLIM_W-1:0] hit_limit;
  logic signed [SW-1:0]         score_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length   <= tkips_pkg::VLEN_RST;
      hit_limit       <= tkips_pkg::HLIM_RST;
      score_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tkips_pkg::CFG_VLEN: vector_length   <= cfg_data[tkips_pkg::VLEN_W-1:0];
        tkips_pkg::CFG_HLIM: hit_limit       <= cfg_data[tkips_pkg::HLIM_W-1:0];
        tkips_pkg::CFG_THR:  score_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective vector length and hit limit.
  logic [31:0] len, lim, idx32, slot32;
  always_comb begin
    if (vector_length == '0) begin
      len = 32'd1;
    end else if (32'(vector_length) > 32'(MAX_LENGTH)) begin
      len = 32'(MAX_LENGTH);
    end else begin
      len = 32'(vector_length);
    end
    lim    = (32'(hit_limit) > 32'(MAX_HITS)) ? 32'(MAX_HITS) : 32'(hit_limit);
    idx32  = 32'(in_idx);
    slot32 = 32'(in_slot);
  end

  logic in_ok, slot_ok;
  assign in_ok   = idx32 < len;
  assign slot_ok = slot32 < 32'(MAX_SLOTS);

  // Slot valid map.
  logic [MAX_SLOTS-1:0] valid;
  logic                 was_present;
  logic [SIW-1:0]       in_slot_ix;
  assign in_slot_ix = slot32[SIW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.store && slot_ok && in_ok && idx32 == len - 32'd1) begin
      valid[in_slot_ix] <= 1'b1;
    end else if (cmd.remove && slot_ok) begin
      valid[in_slot_ix] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      was_present <= slot_ok && valid[in_slot_ix];
    end
  end

  // Search slot and element counters.
  logic [SCW-1:0] s;
  logic [QAW-1:0] d;
  logic [31:0]    s32, d32;
  assign s32 = 32'(s);
  assign d32 = 32'(d);

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      s <= '0;
    end else if (cmd.slot_next) begin
      s <= s + SCW'(1);
    end
    if (cmd.mac_start) begin
      d <= '0;
    end else if (cmd.mac_step) begin
      d <= d + QAW'(1);
    end
  end

  // Gallery and query memories.
  logic            g_we, q_we;
  logic [GAW-1:0]  g_waddr, g_raddr;
  logic [QAW-1:0]  q_waddr;
  logic [tkips_pkg::ELEM_W-1:0] g_rdata, q_rdata;
  logic [31:0]     g_w32, g_r32;

  assign g_we    = cmd.store && slot_ok && in_ok;
  assign q_we    = cmd.query_wr;
  assign g_w32   = slot32 * 32'(MAX_LENGTH) + idx32;
  assign g_r32   = s32 * 32'(MAX_LENGTH) + d32;
  assign g_waddr = g_w32[GAW-1:0];
  assign g_raddr = g_r32[GAW-1:0];
  assign q_waddr = idx32[QAW-1:0];

  tkips_ram #(.WIDTH(tkips_pkg::ELEM_W), .DEPTH(GDEPTH)) u_gallery (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (in_value),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  tkips_ram #(.WIDTH(tkips_pkg::ELEM_W), .DEPTH(MAX_LENGTH)) u_query (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (in_value),
    .raddr (d),
    .rdata (q_rdata)
  );

  // Multiply-accumulate pipeline: read, multiply, accumulate.
  logic iss_v, iss_first, mul_v, mul_first;
  logic signed [2*tkips_pkg::ELEM_W-1:0] prod;
  logic signed [ACCW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_v <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      iss_v <= cmd.mac_step;
      mul_v <= iss_v;
    end
    iss_first <= (d == '0);
    mul_first <= iss_first;
    prod      <= $signed(g_rdata) * $signed(q_rdata);
    if (mul_v) begin
      acc <= mul_first ? ACCW'(prod) : acc + ACCW'(prod);
    end
  end

  // Saturate the finished sum to the score range.
  logic signed [SW-1:0] score;
  always_comb begin
    if (acc > ACCW'(tkips_pkg::SCORE_MAX)) begin
      score = tkips_pkg::SCORE_MAX;
    end else if (acc < ACCW'(tkips_pkg::SCORE_MIN)) begin
      score = tkips_pkg::SCORE_MIN;
    end else begin
      score = acc[SW-1:0];
    end
  end

  // Sorted best list: entries at or above the new score stay in front.
  logic signed [SW-1:0] best_score [MAX_HITS];
  logic [SIW-1:0]       best_slot  [MAX_HITS];
  logic [HCW-1:0]       best_count;
  logic [HIW-1:0]       e;
  logic [MAX_HITS-1:0]  ge;
  logic                 drop, keep;
  logic [31:0]          lim_m1;

  assign lim_m1 = lim - 32'd1;
  always_comb begin
    for (int k = 0; k < MAX_HITS; k++) begin
      ge[k] = (32'(k) < 32'(best_count)) && (best_score[k] >= score);
    end
  end
  assign drop = (lim == 32'd0) || ge[lim_m1[HIW-1:0]];
  assign keep = cmd.insert && (score >= score_threshold) && !drop;

  always_ff @(posedge clk) begin
    if (keep) begin
      for (int k = 0; k < MAX_HITS; k++) begin
        if (!ge[k]) begin
          if (k == 0 || ge[(k > 0) ? k - 1 : 0]) begin
            best_score[k] <= score;
            best_slot[k]  <= s32[SIW-1:0];
          end else begin
            best_score[k] <= best_score[(k > 0) ? k - 1 : 0];
            best_slot[k]  <= best_slot[(k > 0) ? k - 1 : 0];
          end
        end
      end
    end
  end

  logic emit_done, can_load;
  assign emit_done = (best_count == '0) || (32'(e) == 32'(best_count) - 32'd1);
  assign can_load  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_count <= '0;
      e          <= '0;
    end else if (cmd.search_start) begin
      best_count <= '0;
      e          <= '0;
    end else begin
      if (keep && 32'(best_count) < lim) begin
        best_count <= best_count + HCW'(1);
      end
      if (cmd.load_hit) begin
        e <= e + HIW'(1);
      end
    end
  end

  // Output register.
  logic [31:0] hit_slot32;
  assign hit_slot32 = 32'(best_slot[e]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_resp || cmd.load_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_resp) begin
      out_kind        <= tkips_pkg::KIND_REMOVE;
      out_was_present <= was_present;
      out_hit_slot    <= '0;
      out_hit_score   <= '0;
      out_hit_rank    <= '0;
      out_last        <= 1'b1;
    end else if (cmd.load_hit) begin
      out_was_present <= 1'b0;
      if (best_count == '0) begin
        out_kind      <= tkips_pkg::KIND_NOHIT;
        out_hit_slot  <= '0;
        out_hit_score <= '0;
        out_hit_rank  <= '0;
        out_last      <= 1'b1;
      end else begin
        out_kind      <= tkips_pkg::KIND_HIT;
        out_hit_slot  <= hit_slot32[tkips_pkg::SLOT_W-1:0];
        out_hit_score <= best_score[e];
        out_hit_rank  <= tkips_pkg::RANK_W'(32'(e));
        out_last      <= emit_done;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts.in_ok      = in_ok;
    sts.is_final   = (idx32 == len - 32'd1);
    sts.slot_done  = (s32 >= 32'(MAX_SLOTS));
    sts.slot_valid = valid[s32[SIW-1:0]];
    sts.mac_last   = (d32 == len - 32'd1);
    sts.pipe_busy  = iss_v || mul_v;
    sts.emit_done  = emit_done;
    sts.can_load   = can_load;
  end

endmodule

FILE: sv/topk_inner_product_search_unit.sv
// Top-k inner product search over a gallery of fixed slots.
// Input stream s_axis: tuser carries the mode, tdata the slot, element index
// and Q1.15 element. Store and query elements are taken while the unit is idle;
// a store writes the gallery memory, a query element the query buffer.
// A remove answers with one result carrying was_present.
// The query element at index vector_length-1 starts a search: each slot is
// checked in turn, and each valid slot runs one multiply-accumulate per
// element through a single MAC unit fed by the gallery and query memory read
// ports. Up to hit_limit hits (at most MAX_HITS) follow, one per cycle while
// the receiver is ready, best first, or one no-hit result.
// Output stream m_axis: tuser carries the kind, tlast marks the last result
// of an input. The output register holds a result while the receiver stalls;
// emission waits, and the input stays blocked until every result of a remove
// or a query is loaded.
// Reset clears the slot valid map, the controller and the output valid flag and
// restores the configuration defaults; memory contents are not cleared.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once.
module topk_inner_product_search_unit #(
  parameter int MAX_SLOTS  = 64,
  parameter int MAX_LENGTH = 512,
  parameter int MAX_HITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tkips_pkg::CFGI_W-1:0]          cfg_index,
  input  logic [tkips_pkg::SCORE_W-1:0]         cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // slot[5:0], element_index[14:6], element_value[30:15], zero[31]
  input  logic [tkips_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // mode[1:0]
  input  logic [tkips_pkg::MODE_W-1:0]          s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // was_present[0], hit_slot[6:1], hit_score[45:7], hit_rank[48:46], zero[55:49]
  output logic [tkips_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // kind[1:0]
  output logic [tkips_pkg::KIND_W-1:0]          m_axis_tuser,
  output logic                                  m_axis_tlast
);

  tkips_pkg::cmd_t cmd;
  tkips_pkg::sts_t sts;

  logic                             was_present;
  logic [tkips_pkg::SLOT_W-1:0]     hit_slot;
  logic signed [tkips_pkg::SCORE_W-1:0] hit_score;
  logic [tkips_pkg::RANK_W-1:0]     hit_rank;

  tkips_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  tkips_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_HITS   (MAX_HITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_slot         (s_axis_tdata[5:0]),
    .in_idx          (s_axis_tdata[14:6]),
    .in_value        (s_axis_tdata[30:15]),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_kind        (m_axis_tuser),
    .out_was_present (was_present),
    .out_hit_slot    (hit_slot),
    .out_hit_score   (hit_score),
    .out_hit_rank    (hit_rank),
    .out_last        (m_axis_tlast)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {7'd0, hit_rank, hit_score, hit_slot, was_present};

endmodule

FILE: sv/tkips_chk.sv
module tkips_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tkips_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [tkips_pkg::KIND_W-1:0]      m_axis_tuser,
  input logic                              m_axis_tlast
);

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A no-hit result is a single, empty result.
  a_nohit_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tkips_pkg::KIND_NOHIT |->
      m_axis_tlast && m_axis_tdata == '0)
    else $error("malformed no-hit result");

  // A remove answer is single and carries only was_present.
  a_remove_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tkips_pkg::KIND_REMOVE |->
      m_axis_tlast && m_axis_tdata[55:1] == '0)
    else $error("malformed remove answer");

  // No input is accepted while a hit that is not the last one is taken.
  a_hit_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == tkips_pkg::KIND_HIT
      && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a hit list");

endmodule

bind topk_inner_product_search_unit tkips_chk u_tkips_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
